// ===== sv/hrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and match strings for the HTTP request parser.
package hrp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int OUT_LEN_W   = 32;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [4:0]             midx_t;
  typedef logic [2:0]             fstep_t;

  typedef enum logic [1:0] {
    PH_REQ  = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    HK_UNDEC = 2'd0,
    HK_CONN  = 2'd1,
    HK_CLEN  = 2'd2,
    HK_SKIP  = 2'd3
  } hkind_t;

  // request line field steps
  localparam fstep_t FS_METHOD = 3'd0;
  localparam fstep_t FS_URL0   = 3'd1;
  localparam fstep_t FS_PFX    = 3'd2;
  localparam fstep_t FS_HOST   = 3'd3;
  localparam fstep_t FS_PATH   = 3'd4;
  localparam fstep_t FS_VER    = 3'd5;

  // header line field steps
  localparam fstep_t HS_NAME = 3'd0;
  localparam fstep_t HS_PRE  = 3'd1;
  localparam fstep_t HS_VAL  = 3'd2;

  localparam midx_t GET_LEN  = 5'd3;
  localparam midx_t PFX_LEN  = 5'd7;
  localparam midx_t VER_LEN  = 5'd8;
  localparam midx_t CONN_LEN = 5'd11;
  localparam midx_t CLEN_LEN = 5'd15;
  localparam midx_t KA_LEN   = 5'd10;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_N  = 8'h4e;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } item_t;

  typedef struct packed {
    logic                 outcome;
    logic                 keep_alive;
    logic [OUT_LEN_W-1:0] body_length;
  } result_t;

  function automatic logic [7:0] up_case(input logic [7:0] b);
    if (b >= CH_LO_A && b <= CH_LO_Z) return b - 8'd32;
    return b;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic [7:0] get_char(input midx_t idx);
    case (idx)
      5'd0:    return "G";
      5'd1:    return "E";
      5'd2:    return "T";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ver_char(input midx_t idx);
    case (idx)
      5'd0:    return "H";
      5'd1:    return "T";
      5'd2:    return "T";
      5'd3:    return "P";
      5'd4:    return "/";
      5'd5:    return "1";
      5'd6:    return ".";
      5'd7:    return "1";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] pfx_char(input midx_t idx);
    case (idx)
      5'd0:    return "H";
      5'd1:    return "T";
      5'd2:    return "T";
      5'd3:    return "P";
      5'd4:    return ":";
      5'd5:    return "/";
      5'd6:    return "/";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] conn_char(input midx_t idx);
    case (idx)
      5'd0:    return "C";
      5'd1:    return "O";
      5'd2:    return "N";
      5'd3:    return "N";
      5'd4:    return "E";
      5'd5:    return "C";
      5'd6:    return "T";
      5'd7:    return "I";
      5'd8:    return "O";
      5'd9:    return "N";
      5'd10:   return ":";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] clen_char(input midx_t idx);
    case (idx)
      5'd0:    return "C";
      5'd1:    return "O";
      5'd2:    return "N";
      5'd3:    return "T";
      5'd4:    return "E";
      5'd5:    return "N";
      5'd6:    return "T";
      5'd7:    return "-";
      5'd8:    return "L";
      5'd9:    return "E";
      5'd10:   return "N";
      5'd11:   return "G";
      5'd12:   return "T";
      5'd13:   return "H";
      5'd14:   return ":";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ka_char(input midx_t idx);
    case (idx)
      5'd0:    return "K";
      5'd1:    return "E";
      5'd2:    return "E";
      5'd3:    return "P";
      5'd4:    return "-";
      5'd5:    return "A";
      5'd6:    return "L";
      5'd7:    return "I";
      5'd8:    return "V";
      5'd9:    return "E";
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ===== sv/hrp_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the HTTP request parser: holds one accepted byte until parsed.
module hrp_in_stage import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_new_request,
  input  logic       ready,
  output logic       take,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !ready;
  assign load     = in_valid && !in_stall;
  assign take     = valid_r && ready;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte   <= in_data_byte;
      item_r.new_request <= in_new_request;
    end
  end

endmodule

// ===== sv/hrp_parser.sv =====
`timescale 1ns / 1ps
// Parser state and the per-byte next-state and result logic.
module hrp_parser import hrp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   item,
  output logic    emit,
  output result_t result
);

  phase_t ph_r, ph_b, ph_nxt;
  fstep_t fs_r, fs_b, fs_nxt;
  midx_t  mi_r, mi_b, mi_nxt;
  hkind_t hk_r, hk_b, hk_nxt;
  logic   mg_r, mg_b, mg_nxt;
  logic   cr_r, cr_b, cr_nxt;
  logic   le_r, le_b, le_nxt;
  logic   ka_r, ka_b, ka_nxt;
  len_t   len_r, len_b, len_nxt;
  len_t   bc_r, bc_b, bc_nxt;

  logic [7:0]         b;
  logic [7:0]         ub;
  logic               sep;
  logic               dig;
  logic [LENGTH_BITS:0] bc_inc;
  logic               req_bad;
  logic               ver_ok;
  logic               bad;
  logic               val_now;

  function automatic len_t add_digit(input len_t v, input logic [7:0] ch);
    logic [LENGTH_BITS+3:0] acc;
    acc = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (LENGTH_BITS + 4)'(ch[3:0]);
    if (|acc[LENGTH_BITS+3:LENGTH_BITS]) return '1;
    return acc[LENGTH_BITS-1:0];
  endfunction

  // new_request restarts the parse before the byte is looked at
  always_comb begin
    if (item.new_request) begin
      ph_b  = PH_REQ;
      fs_b  = FS_METHOD;
      mi_b  = '0;
      hk_b  = HK_UNDEC;
      mg_b  = 1'b1;
      cr_b  = 1'b0;
      le_b  = 1'b1;
      ka_b  = 1'b0;
      len_b = '0;
      bc_b  = '0;
    end else begin
      ph_b  = ph_r;
      fs_b  = fs_r;
      mi_b  = mi_r;
      hk_b  = hk_r;
      mg_b  = mg_r;
      cr_b  = cr_r;
      le_b  = le_r;
      ka_b  = ka_r;
      len_b = len_r;
      bc_b  = bc_r;
    end
  end

  assign b      = item.data_byte;
  assign ub     = up_case(b);
  assign sep    = is_sep(b);
  assign dig    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign bc_inc = {1'b0, bc_b} + (LENGTH_BITS + 1)'(1);
  assign ver_ok = (fs_b == FS_VER) && mg_b && (mi_b == VER_LEN);

  // request line bytes that make the request certainly bad
  always_comb begin
    case (fs_b)
      FS_METHOD: req_bad = sep && !(mg_b && mi_b == GET_LEN);
      FS_URL0:   req_bad = sep || !(b == CH_SLASH || ub == CH_UP_H);
      FS_PFX:    req_bad = sep || (mi_b >= PFX_LEN) || (ub != pfx_char(mi_b));
      FS_HOST:   req_bad = sep;
      default:   req_bad = 1'b0;
    endcase
  end

  // outputs: whether this byte ends the request, and how
  always_comb begin
    emit = 1'b0;
    bad  = 1'b0;
    unique case (ph_b)
      PH_BODY: emit = (bc_inc >= {1'b0, len_b});
      PH_DONE: emit = 1'b0;
      default: begin
        if (cr_b) begin
          if (b != CH_LF) begin
            emit = 1'b1;
            bad  = 1'b1;
          end else if (ph_b == PH_REQ) begin
            emit = !ver_ok;
            bad  = !ver_ok;
          end else begin
            emit = le_b && (len_b == '0);
          end
        end else if (b == CH_LF) begin
          emit = 1'b1;
          bad  = 1'b1;
        end else if (b != CH_CR && ph_b == PH_REQ) begin
          emit = req_bad;
          bad  = req_bad;
        end
      end
    endcase
    result.outcome     = bad;
    result.keep_alive  = bad ? 1'b0 : ka_b;
    result.body_length = bad ? '0 : OUT_LEN_W'(len_b);
  end

  // next state
  always_comb begin
    ph_nxt  = ph_b;
    fs_nxt  = fs_b;
    mi_nxt  = mi_b;
    hk_nxt  = hk_b;
    mg_nxt  = mg_b;
    cr_nxt  = cr_b;
    le_nxt  = le_b;
    ka_nxt  = ka_b;
    len_nxt = len_b;
    bc_nxt  = bc_b;
    val_now = 1'b0;
    unique case (ph_b)
      PH_BODY: bc_nxt = bc_inc[LENGTH_BITS-1:0];
      PH_DONE: ph_nxt = PH_DONE;
      default: begin
        if (cr_b) begin
          cr_nxt = 1'b0;
          if (ph_b == PH_REQ) begin
            ph_nxt = PH_HDR;
          end else if (le_b) begin
            ph_nxt = PH_BODY;
            bc_nxt = '0;
          end else if (hk_b == HK_CONN && fs_b >= HS_PRE && mg_b && mi_b == KA_LEN) begin
            ka_nxt = 1'b1;
          end
          fs_nxt = FS_METHOD;
          mi_nxt = '0;
          hk_nxt = HK_UNDEC;
          mg_nxt = 1'b1;
          le_nxt = 1'b1;
        end else if (b == CH_CR) begin
          cr_nxt = 1'b1;
        end else if (b != CH_LF) begin
          le_nxt = 1'b0;
          if (ph_b == PH_REQ) begin
            case (fs_b)
              FS_METHOD: begin
                if (sep) begin
                  fs_nxt = FS_URL0;
                  mi_nxt = '0;
                  mg_nxt = 1'b1;
                end else begin
                  if (mi_b >= GET_LEN || ub != get_char(mi_b)) mg_nxt = 1'b0;
                  if (mi_b < GET_LEN + 5'd1) mi_nxt = mi_b + 5'd1;
                end
              end
              FS_URL0: begin
                if (b == CH_SLASH) begin
                  fs_nxt = FS_PATH;
                end else if (ub == CH_UP_H) begin
                  fs_nxt = FS_PFX;
                  mi_nxt = 5'd1;
                end
              end
              FS_PFX: begin
                mi_nxt = mi_b + 5'd1;
                if (mi_b + 5'd1 == PFX_LEN) fs_nxt = FS_HOST;
              end
              FS_HOST: begin
                if (b == CH_SLASH) fs_nxt = FS_PATH;
              end
              FS_PATH: begin
                if (sep) begin
                  fs_nxt = FS_VER;
                  mi_nxt = '0;
                  mg_nxt = 1'b1;
                end
              end
              default: begin
                if (mi_b >= VER_LEN || ub != ver_char(mi_b)) mg_nxt = 1'b0;
                if (mi_b < VER_LEN + 5'd1) mi_nxt = mi_b + 5'd1;
              end
            endcase
          end else if (hk_b != HK_SKIP) begin
            if (fs_b == HS_NAME) begin
              case (hk_b)
                HK_UNDEC: begin
                  if (mi_b < GET_LEN) begin
                    if (ub != conn_char(mi_b)) hk_nxt = HK_SKIP;
                    mi_nxt = mi_b + 5'd1;
                  end else begin
                    // fourth letter tells Connection from Content-Length
                    if (ub == CH_UP_N) hk_nxt = HK_CONN;
                    else if (ub == CH_UP_T) hk_nxt = HK_CLEN;
                    else hk_nxt = HK_SKIP;
                    mi_nxt = 5'd4;
                  end
                end
                HK_CONN: begin
                  if (mi_b >= CONN_LEN || ub != conn_char(mi_b)) begin
                    hk_nxt = HK_SKIP;
                  end else if (mi_b == CONN_LEN - 5'd1) begin
                    fs_nxt = HS_PRE;
                    mi_nxt = '0;
                    mg_nxt = 1'b1;
                  end else begin
                    mi_nxt = mi_b + 5'd1;
                  end
                end
                default: begin
                  if (mi_b >= CLEN_LEN || ub != clen_char(mi_b)) begin
                    hk_nxt = HK_SKIP;
                  end else if (mi_b == CLEN_LEN - 5'd1) begin
                    fs_nxt  = HS_PRE;
                    mi_nxt  = '0;
                    len_nxt = '0;
                  end else begin
                    mi_nxt = mi_b + 5'd1;
                  end
                end
              endcase
            end else begin
              val_now = 1'b1;
              if (fs_b == HS_PRE) begin
                if (sep) begin
                  val_now = 1'b0;
                end else begin
                  fs_nxt = HS_VAL;
                  if (hk_b == HK_CLEN) begin
                    // first value byte of Content-Length may be a plus sign
                    val_now = 1'b0;
                    if (b != CH_PLUS) begin
                      if (dig) len_nxt = add_digit(len_b, b);
                      else hk_nxt = HK_SKIP;
                    end
                  end
                end
              end
              if (val_now) begin
                if (hk_b == HK_CONN) begin
                  if (mi_b >= KA_LEN || ub != ka_char(mi_b)) mg_nxt = 1'b0;
                  if (mi_b < KA_LEN + 5'd1) mi_nxt = mi_b + 5'd1;
                end else begin
                  if (dig) len_nxt = add_digit(len_b, b);
                  else hk_nxt = HK_SKIP;
                end
              end
            end
          end
        end
      end
    endcase
    if (emit) ph_nxt = PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_REQ;
      fs_r  <= FS_METHOD;
      mi_r  <= '0;
      hk_r  <= HK_UNDEC;
      mg_r  <= 1'b1;
      cr_r  <= 1'b0;
      le_r  <= 1'b1;
      ka_r  <= 1'b0;
      len_r <= '0;
      bc_r  <= '0;
    end else if (take) begin
      ph_r  <= ph_nxt;
      fs_r  <= fs_nxt;
      mi_r  <= mi_nxt;
      hk_r  <= hk_nxt;
      mg_r  <= mg_nxt;
      cr_r  <= cr_nxt;
      le_r  <= le_nxt;
      ka_r  <= ka_nxt;
      len_r <= len_nxt;
      bc_r  <= bc_nxt;
    end
  end

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ph_r == PH_DONE && !item.new_request) |-> !emit)
    else $error("result emitted after the request was finished");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit) |=> (ph_r == PH_DONE))
    else $error("parser did not stop after a result");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_BODY) |-> (bc_r < len_r))
    else $error("body count reached length without a result");

endmodule

// ===== sv/hrp_out_stage.sv =====
`timescale 1ns / 1ps
// Result register of the HTTP request parser with its valid/stall handshake.
module hrp_out_stage import hrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  result_t              result,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_outcome,
  output logic                 out_keep_alive,
  output logic [OUT_LEN_W-1:0] out_body_length
);

  logic    valid_r;
  result_t res_r;

  // a held result that is being taken frees the register this cycle
  assign ready           = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_outcome     = res_r.outcome;
  assign out_keep_alive  = res_r.keep_alive;
  assign out_body_length = res_r.body_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

endmodule

// ===== sv/http_request_parser_top.sv =====
`timescale 1ns / 1ps
// HTTP/1.1 request header parser. Takes one request byte per item and can accept an
// item every clock cycle. The byte sits in an input register, the parser state (request
// line match, header match, Content-Length accumulate with saturation, body byte count)
// advances once per byte, and the result (complete GET or bad request) that the byte
// decides goes to an output register and shows on out_valid. Input flows at full rate
// as long as results are taken when offered. While a result is held by out_stall, the
// input register keeps one byte and then stalls. After a result, bytes are absorbed
// without output until an item with new_request set restarts the parse. The state
// update, whose longest path is the Content-Length times-ten add and overflow check,
// sets the rate.
module http_request_parser_top import hrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_new_request,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_outcome,
  output logic                 out_keep_alive,
  output logic [OUT_LEN_W-1:0] out_body_length
);

  logic    ready;
  logic    take;
  logic    emit;
  item_t   item;
  result_t result;

  hrp_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_new_request (in_new_request),
    .ready          (ready),
    .take           (take),
    .item           (item)
  );

  hrp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (item),
    .emit   (emit),
    .result (result)
  );

  hrp_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (take && emit),
    .result          (result),
    .ready           (ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_keep_alive  (out_keep_alive),
    .out_body_length (out_body_length)
  );

endmodule
